// ===== src/salc_pkg.sv =====
package salc_pkg;

   localparam int SALC_MAX_SET_BITS = 6;
   localparam int SALC_MAX_WAYS     = 8;
   localparam int SET_FIELD_W       = 12;   // widest set index any build can use
   localparam int QUEUE_DEPTH       = 2;

   // access kinds on the request word
   localparam logic [1:0] ACT_LOAD   = 2'd0;
   localparam logic [1:0] ACT_MODIFY = 2'd1;
   localparam logic [1:0] ACT_IFETCH = 2'd2;

   // result outcome codes
   localparam logic [1:0] OUT_HIT    = 2'd0;
   localparam logic [1:0] OUT_FILL   = 2'd1;
   localparam logic [1:0] OUT_EVICT  = 2'd2;
   localparam logic [1:0] OUT_IGNORE = 2'd3;

   // register indexes
   localparam logic [1:0] CSR_SET_BITS   = 2'd0;
   localparam logic [1:0] CSR_BLOCK_BITS = 2'd1;
   localparam logic [1:0] CSR_WAYS       = 2'd2;

   typedef struct packed {
      logic [2:0] set_bits;
      logic [4:0] block_bits;
      logic [3:0] ways;
   } cfg_type;

   // classified access handed from front to back
   typedef struct packed {
      logic [1:0]             kind;
      logic [31:0]            tag;
      logic [SET_FIELD_W-1:0] set;
   } entry_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] tag;
      logic [31:0] age;
   } line_type;

endpackage

// ===== src/salc_ifs.sv =====
interface salc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [31:0] address;
   modport source (output valid, action, address, input ready);
   modport sink   (input valid, action, address, output ready);
endinterface

interface salc_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  outcome;
   logic [2:0]  way_used;
   logic [31:0] hit_total;
   logic [31:0] miss_total;
   logic [31:0] eviction_total;
   modport source (output valid, outcome, way_used, hit_total, miss_total, eviction_total,
                   input ready);
   modport sink   (input valid, outcome, way_used, hit_total, miss_total, eviction_total,
                   output ready);
endinterface

interface salc_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/salc_front.sv =====
module salc_front
   import salc_pkg::*;
#(
   parameter int MAX_SET_BITS = SALC_MAX_SET_BITS
) (
   salc_req_if.sink  req,
   input  cfg_type   cfg,
   input  logic      clearing,
   output logic      q_valid,
   input  logic      q_ready,
   output entry_type q_entry
);

   logic [3:0]  sb_eff;
   logic [5:0]  pos;
   logic [31:0] set_mask;
   logic [31:0] max_mask;
   logic [31:0] set_raw;

   assign req.ready = !clearing && q_ready;
   assign q_valid   = req.valid && !clearing;

   always_comb begin
      sb_eff   = (32'(cfg.set_bits) > MAX_SET_BITS) ? 4'(MAX_SET_BITS) : 4'(cfg.set_bits);
      pos      = 6'(sb_eff) + 6'(cfg.block_bits);
      max_mask = (32'd1 << MAX_SET_BITS) - 32'd1;
      // index and offset covering the whole word: tag is zero, index takes all above offset
      set_mask = (pos >= 6'd32) ? '1 : ((32'd1 << sb_eff) - 32'd1);
      set_raw  = req.address >> cfg.block_bits;

      q_entry.tag  = (pos >= 6'd32) ? 32'd0 : (req.address >> pos[4:0]);
      q_entry.set  = SET_FIELD_W'(set_raw & set_mask & max_mask);
      case (req.action)
         ACT_MODIFY: q_entry.kind = ACT_MODIFY;
         ACT_IFETCH: q_entry.kind = ACT_IFETCH;
         default:    q_entry.kind = ACT_LOAD;   // spare code acts as load/store
      endcase
   end

endmodule

// ===== src/salc_queue.sv =====
module salc_queue
   import salc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  entry_type in_entry,
   output logic      out_valid,
   input  logic      out_ready,
   output entry_type out_entry
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   entry_type        slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wptr_ff, wptr_in;
   logic [PTR_W-1:0] rptr_ff, rptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign in_ready  = (32'(count_ff) < QUEUE_DEPTH);
   assign out_valid = (count_ff != '0);
   assign out_entry = slot_ff[rptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (push)
         wptr_in = (32'(wptr_ff) == QUEUE_DEPTH - 1) ? '0 : wptr_ff + 1'b1;
      if (pop)
         rptr_in = (32'(rptr_ff) == QUEUE_DEPTH - 1) ? '0 : rptr_ff + 1'b1;
      if (push && !pop)
         count_in = count_ff + 1'b1;
      else if (pop && !push)
         count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
      if (push)
         slot_ff[wptr_ff] <= in_entry;
   end

endmodule

// ===== src/salc_back.sv =====
module salc_back
   import salc_pkg::*;
#(
   parameter int MAX_SET_BITS = SALC_MAX_SET_BITS,
   parameter int MAX_WAYS     = SALC_MAX_WAYS
) (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       q_valid,
   output logic       q_ready,
   input  entry_type  q_entry,
   output logic       clearing,
   salc_rsp_if.source rsp
);

   localparam int LINES = (1 << MAX_SET_BITS) * MAX_WAYS;
   localparam int IDX_W = (LINES > 1) ? $clog2(LINES) : 1;
   localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int CNT_W = $clog2(MAX_WAYS + 1);
   localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;

   localparam logic [2:0] ST_CLR  = 3'd0;
   localparam logic [2:0] ST_IDLE = 3'd1;
   localparam logic [2:0] ST_RD   = 3'd2;
   localparam logic [2:0] ST_DEC  = 3'd3;
   localparam logic [2:0] ST_WR   = 3'd4;
   localparam logic [2:0] ST_OUT  = 3'd5;

   line_type mem [LINES];

   logic [2:0]       state_ff, state_in;
   logic [IDX_W-1:0] clr_ff, clr_in;
   entry_type        entry_ff, entry_in;
   logic [IDX_W-1:0] base_ff, base_in;
   logic [CNT_W-1:0] iss_ff, iss_in;
   logic             rv_ff, rv_in;
   logic [WAY_W-1:0] rway_ff, rway_in;
   line_type         rdata_ff;
   line_type         lane_ff [MAX_WAYS];
   line_type         lane_in [MAX_WAYS];
   logic             hfnd_ff, hfnd_in, ffnd_ff, ffnd_in;
   logic [WAY_W-1:0] hway_ff, hway_in, fway_ff, fway_in, oway_ff, oway_in;
   logic [31:0]      oage_ff, oage_in;
   logic [WAY_W-1:0] pick_ff, pick_in;
   logic [1:0]       outc_ff, outc_in;
   logic [WAY_W-1:0] wcnt_ff, wcnt_in;
   logic [31:0]      hits_ff, hits_in, miss_ff, miss_in, evic_ff, evic_in;
   logic             rv_out_ff, rv_out_in;
   logic [1:0]       r_outc_ff, r_outc_in;
   logic [2:0]       r_way_ff, r_way_in;
   logic [31:0]      r_hits_ff, r_hits_in, r_miss_ff, r_miss_in, r_evic_ff, r_evic_in;

   logic [CNT_W-1:0] nw;
   logic             we;
   logic [IDX_W-1:0] waddr, raddr;
   line_type         wdata;

   assign clearing           = (state_ff == ST_CLR);
   assign q_ready            = (state_ff == ST_IDLE);
   assign rsp.valid          = rv_out_ff;
   assign rsp.outcome        = r_outc_ff;
   assign rsp.way_used       = r_way_ff;
   assign rsp.hit_total      = r_hits_ff;
   assign rsp.miss_total     = r_miss_ff;
   assign rsp.eviction_total = r_evic_ff;

   always_comb begin
      nw = (cfg.ways == 4'd0) ? CNT_W'(1) :
           ((32'(cfg.ways) > MAX_WAYS) ? CNT_W'(MAX_WAYS) : CNT_W'(cfg.ways));
   end

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      entry_in = entry_ff;
      base_in  = base_ff;
      iss_in   = iss_ff;
      rv_in    = 1'b0;
      rway_in  = rway_ff;
      lane_in  = lane_ff;
      hfnd_in  = hfnd_ff;
      ffnd_in  = ffnd_ff;
      hway_in  = hway_ff;
      fway_in  = fway_ff;
      oway_in  = oway_ff;
      oage_in  = oage_ff;
      pick_in  = pick_ff;
      outc_in  = outc_ff;
      wcnt_in  = wcnt_ff;
      hits_in  = hits_ff;
      miss_in  = miss_ff;
      evic_in  = evic_ff;
      we       = 1'b0;
      waddr    = base_ff + IDX_W'(wcnt_ff);
      wdata    = '0;
      raddr    = base_ff + IDX_W'(iss_ff);

      rv_out_in = rv_out_ff && !rsp.ready;
      r_outc_in = r_outc_ff;
      r_way_in  = r_way_ff;
      r_hits_in = r_hits_ff;
      r_miss_in = r_miss_ff;
      r_evic_in = r_evic_ff;

      case (state_ff)
         ST_CLR: begin
            we     = 1'b1;
            waddr  = clr_ff;
            clr_in = clr_ff + 1'b1;
            if (32'(clr_ff) == LINES - 1)
               state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (q_valid) begin
               entry_in = q_entry;
               if (q_entry.kind == ACT_IFETCH) begin
                  outc_in  = OUT_IGNORE;
                  pick_in  = '0;
                  state_in = ST_OUT;
               end else begin
                  if (q_entry.kind == ACT_MODIFY)
                     hits_in = hits_ff + 32'd1;
                  base_in  = IDX_W'(q_entry.set[SET_W-1:0]) * IDX_W'(nw);
                  iss_in   = '0;
                  hfnd_in  = 1'b0;
                  ffnd_in  = 1'b0;
                  hway_in  = '0;
                  fway_in  = '0;
                  oway_in  = '0;
                  oage_in  = '0;
                  state_in = ST_RD;
               end
            end
         end
         ST_RD: begin
            if (iss_ff < nw) begin
               iss_in  = iss_ff + 1'b1;
               rv_in   = 1'b1;
               rway_in = WAY_W'(iss_ff);
            end
            if (rv_ff) begin
               lane_in[rway_ff] = rdata_ff;
               if (rdata_ff.valid && rdata_ff.tag == entry_ff.tag && !hfnd_ff) begin
                  hfnd_in = 1'b1;
                  hway_in = rway_ff;
               end
               if (!rdata_ff.valid && !ffnd_ff) begin
                  ffnd_in = 1'b1;
                  fway_in = rway_ff;
               end
               if (rdata_ff.age > oage_ff) begin
                  oage_in = rdata_ff.age;
                  oway_in = rway_ff;
               end
               if (32'(rway_ff) + 1 == 32'(nw))
                  state_in = ST_DEC;
            end
         end
         ST_DEC: begin
            if (hfnd_ff) begin
               hits_in = hits_ff + 32'd1;
               pick_in = hway_ff;
               outc_in = OUT_HIT;
            end else begin
               miss_in = miss_ff + 32'd1;
               if (ffnd_ff) begin
                  pick_in = fway_ff;
                  outc_in = OUT_FILL;
               end else begin
                  evic_in = evic_ff + 32'd1;
                  pick_in = oway_ff;
                  outc_in = OUT_EVICT;
               end
            end
            wcnt_in  = '0;
            state_in = ST_WR;
         end
         ST_WR: begin
            we = 1'b1;
            if (wcnt_ff == pick_ff) begin
               wdata.valid = 1'b1;
               wdata.tag   = entry_ff.tag;
               wdata.age   = 32'd0;
            end else begin
               wdata     = lane_ff[wcnt_ff];
               wdata.age = lane_ff[wcnt_ff].age + 32'd1;
            end
            wcnt_in = wcnt_ff + 1'b1;
            if (32'(wcnt_ff) + 1 == 32'(nw))
               state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rv_out_ff || rsp.ready) begin
               rv_out_in = 1'b1;
               r_outc_in = outc_ff;
               r_way_in  = 3'(pick_ff);
               r_hits_in = hits_ff;
               r_miss_in = miss_ff;
               r_evic_in = evic_ff;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we)
         mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLR;
         clr_ff    <= '0;
         rv_ff     <= 1'b0;
         rv_out_ff <= 1'b0;
         hits_ff   <= '0;
         miss_ff   <= '0;
         evic_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         rv_ff     <= rv_in;
         rv_out_ff <= rv_out_in;
         hits_ff   <= hits_in;
         miss_ff   <= miss_in;
         evic_ff   <= evic_in;
      end
      entry_ff  <= entry_in;
      base_ff   <= base_in;
      iss_ff    <= iss_in;
      rway_ff   <= rway_in;
      lane_ff   <= lane_in;
      hfnd_ff   <= hfnd_in;
      ffnd_ff   <= ffnd_in;
      hway_ff   <= hway_in;
      fway_ff   <= fway_in;
      oway_ff   <= oway_in;
      oage_ff   <= oage_in;
      pick_ff   <= pick_in;
      outc_ff   <= outc_in;
      wcnt_ff   <= wcnt_in;
      r_outc_ff <= r_outc_in;
      r_way_ff  <= r_way_in;
      r_hits_ff <= r_hits_in;
      r_miss_ff <= r_miss_in;
      r_evic_ff <= r_evic_in;
   end

endmodule

// ===== src/set_assoc_lru_cache_sim.sv =====
// Channel   Dir  Word carried                                        Accepted when
// req       in   action[1:0], address[31:0]                          req.valid & req.ready
// rsp       out  outcome, way_used, hit/miss/eviction totals         rsp.valid & rsp.ready
// csr       in   index[1:0] (0 set_bits, 1 block_bits, 2 ways), data  csr.valid & csr.ready
//
// Per access word, a load/store/modify with W ways in use reads each of the W lines of
// its set, then writes each back to the line store; a fetch touches no line.
// Reset (synchronous, high) starts a clearing pass over all (2**MAX_SET_BITS)*MAX_WAYS
// lines, one a cycle (512 lines at defaults); req.ready stays low until it ends.
// A two-word queue sits between classification and the lookup engine; the result
// register frees the engine while a word waits on rsp. csr is always ready.
module set_assoc_lru_cache_sim
   import salc_pkg::*;
#(
   parameter int MAX_SET_BITS = SALC_MAX_SET_BITS,
   parameter int MAX_WAYS     = SALC_MAX_WAYS
) (
   input logic        clock,
   input logic        reset,
   salc_req_if.sink   req,
   salc_rsp_if.source rsp,
   salc_csr_if.sink   csr
);

   cfg_type   cfg_ff, cfg_in;
   logic      clearing;
   logic      fq_valid, fq_ready;
   entry_type fq_entry;
   logic      qb_valid, qb_ready;
   entry_type qb_entry;

   assign csr.ready = 1'b1;

   // register writes; unknown indexes fall through
   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         case (csr.index)
            CSR_SET_BITS:   cfg_in.set_bits   = csr.data[2:0];
            CSR_BLOCK_BITS: cfg_in.block_bits = csr.data[4:0];
            CSR_WAYS:       cfg_in.ways       = csr.data[3:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.set_bits   <= 3'd0;
         cfg_ff.block_bits <= 5'd0;
         cfg_ff.ways       <= 4'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: split address into tag and set
   salc_front #(.MAX_SET_BITS(MAX_SET_BITS)) u_front (
      .req      (req),
      .cfg      (cfg_ff),
      .clearing (clearing),
      .q_valid  (fq_valid),
      .q_ready  (fq_ready),
      .q_entry  (fq_entry)
   );

   salc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_entry  (fq_entry),
      .out_valid (qb_valid),
      .out_ready (qb_ready),
      .out_entry (qb_entry)
   );

   // back: set walk, victim choice, age update, counters
   salc_back #(.MAX_SET_BITS(MAX_SET_BITS), .MAX_WAYS(MAX_WAYS)) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .q_valid  (qb_valid),
      .q_ready  (qb_ready),
      .q_entry  (qb_entry),
      .clearing (clearing),
      .rsp      (rsp)
   );

endmodule

// ===== src/salc_checker.sv =====
module salc_checker
   import salc_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_outcome,
   input logic [2:0]  rsp_way_used,
   input logic [31:0] rsp_hit_total
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp word dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_hit_total) && $stable(rsp_outcome))
      else $error("rsp word changed while stalled");

   a_ignore_way: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_outcome == OUT_IGNORE |-> rsp_way_used == 3'd0)
      else $error("ignored access reports a way");

   a_clear_blocks: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request taken during clearing pass");

endmodule

bind set_assoc_lru_cache_sim salc_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req.ready),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .rsp_outcome   (rsp.outcome),
   .rsp_way_used  (rsp.way_used),
   .rsp_hit_total (rsp.hit_total)
);
